// ===== design/sivs_pkg.sv =====
// Shared types and constants for the sparse index vector store.
// Used by the top level, the list engine and the port checker; no dependencies.
`timescale 1ns / 1ps

package sivs_pkg;

  localparam int MAX_LENGTH_DEF = 64;

  localparam logic [6:0]  LEN_RESET = 7'd64;
  localparam logic [21:0] SUM_SAT   = 22'h3FFFFF;

  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  typedef struct packed {
    logic        func;
    logic [5:0]  position;
    logic [15:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        had_nonzero;
    logic        range_error;
    logic [6:0]  nonzero_count;
    logic [21:0] total_order;
    logic [15:0] largest_value;
    logic        last_nonzero;
  } out_item_t;

  // One slot of the sorted list.
  typedef struct packed {
    logic [5:0]  pos;
    logic [15:0] val;
  } entry_t;

  // Summary of the committed list.
  typedef struct packed {
    logic [6:0]  count;
    logic [21:0] sum;
    logic [15:0] max;
    logic [5:0]  last_pos;
  } stat_t;

  // What the engine hands back for one item.
  typedef struct packed {
    logic [15:0] read_value;
    logic        had;
    stat_t       stat;
  } res_t;

endpackage

// ===== design/sparse_index_vector_store.sv =====
// Sparse index vector store, top level: handshakes, length register, result register.
// Depends on sivs_pkg and sivs_list.
//
// Usage:
//   in  channel (in_valid/in_ready/in_item): one beat is a set (func 0) or a
//       get (func 1) of one position. A set writes, inserts or (with a zero
//       value) erases; a get reads the value, zero when absent.
//   out channel (out_valid/out_ready/out_item): exactly one beat per input
//       beat, in order, carrying read value, prior presence, range error and
//       the list summary (count, saturated sum, maximum, last component).
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes length_in_use; always
//       ready. Write it only while no item is in flight.
// Timing: each item makes one pass over the whole sorted list held in a
//   single synchronous memory, one slot per cycle, then a finish step
//   commits the list summary and the result waits in the engine for
//   handoff to the result register; a position at or beyond the length in
//   use skips the pass and goes straight to handoff. One item is worked on
//   at a time: the next beat is taken the cycle after a result enters the
//   result register.
// Stall: the result register holds the last result while out_ready is low;
//   the next item is still accepted and worked, and its result waits in the
//   engine until the register frees.
// Reset: list empty, sum and maximum zero, length_in_use = 64. The list
//   memory itself is not cleared; the entry count bounds every read.
`timescale 1ns / 1ps

module sparse_index_vector_store #(
  parameter int MAX_LENGTH = sivs_pkg::MAX_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sivs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sivs_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import sivs_pkg::*;

  logic [6:0]  length_in_use;
  logic        busy;
  logic        range_err;
  logic [31:0] len_eff;
  logic        in_err;
  logic        accept;
  logic        done_valid;
  logic        done_ready;
  res_t        done_res;
  logic        last_hit;

  // Saturate the register to the storage depth
  assign len_eff = (32'(length_in_use) > 32'(MAX_LENGTH)) ? 32'(MAX_LENGTH)
                                                          : 32'(length_in_use);
  assign in_err  = 32'(in_item.position) >= len_eff;

  assign in_ready   = !busy;
  assign accept     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign done_ready = !out_valid || out_ready;

  // Final component is nonzero when the list tail sits at length - 1
  assign last_hit = (done_res.stat.count != 7'd0) && (len_eff != 32'd0) &&
                    (32'(done_res.stat.last_pos) == len_eff - 32'd1);

  sivs_list #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_list (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .skip      (in_err),
    .item      (in_item),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .done_res  (done_res)
  );

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_in_use <= cfg_data;
    end
  end

  // Hold busy from accept until the engine hands the result over
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy      <= 1'b1;
      range_err <= in_err;
    end else if (done_valid && done_ready) begin
      busy <= 1'b0;
    end
  end

  // Result register: load on engine handoff, drop on downstream take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (done_valid && done_ready) begin
        out_valid              <= 1'b1;
        out_item.read_value    <= done_res.read_value;
        out_item.had_nonzero   <= done_res.had;
        out_item.range_error   <= range_err;
        out_item.nonzero_count <= done_res.stat.count;
        out_item.total_order   <= done_res.stat.sum;
        out_item.largest_value <= done_res.stat.max;
        out_item.last_nonzero  <= last_hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/sivs_list.sv =====
// Sorted list engine: list memory, one read/modify/write pass per item that is not skipped.
// Depends on sivs_pkg.
`timescale 1ns / 1ps

module sivs_list #(
  parameter int MAX_LENGTH = sivs_pkg::MAX_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              skip,
  input  sivs_pkg::in_item_t item,
  output logic              done_valid,
  input  logic              done_ready,
  output sivs_pkg::res_t    done_res
);
  import sivs_pkg::*;

  localparam int IDX_W = $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;

  entry_t mem [MAX_LENGTH];
  entry_t mem_q;

  // Committed list state
  logic [CNT_W-1:0] count;
  logic [21:0]      sum;
  logic [15:0]      max;
  logic [5:0]       last_pos;

  // Item under work
  logic        is_get;
  logic [5:0]  p;
  logic [15:0] v;

  // Pass state
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] proc_idx;
  logic             q_valid;
  logic             settled;
  logic             shift_up;
  logic             shift_down;
  entry_t           carry;
  logic [SUM_W-1:0] acc_sum;
  logic [15:0]      acc_max;
  logic [5:0]       acc_last;
  logic             had;
  logic [15:0]      rd_val;
  res_t             res;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             use_en;
  entry_t           use_e;
  logic             found_set;
  logic             settle;
  logic             up_set;
  logic             down_set;
  logic             carry_ld;
  logic             set_nz;
  logic             room;
  logic [CNT_W-1:0] prev_idx;
  entry_t           new_e;

  logic             add_en;
  entry_t           add_e;
  logic [CNT_W-1:0] count_fin;
  logic [SUM_W-1:0] sum_fin;
  logic [21:0]      sum_sat;
  logic [15:0]      max_fin;
  logic [5:0]       last_fin;

  assign set_nz   = (is_get == FUNC_SET) && (v != 16'd0);
  assign room     = count < MAX_CNT;
  assign prev_idx = proc_idx - CNT_W'(1);
  assign new_e    = '{pos: p, val: v};

  assign rd_en   = (state == S_SCAN) && (rd_idx < count);
  assign rd_addr = rd_idx[IDX_W-1:0];

  // End of pass: append the shifted-out carry or a new tail entry
  always_comb begin
    add_en = 1'b0;
    add_e  = carry;
    if (shift_up) begin
      add_en = 1'b1;
    end else if (!settled && set_nz && room) begin
      add_en = 1'b1;
      add_e  = new_e;
    end
    count_fin = count + CNT_W'(add_en) - CNT_W'(shift_down);
    sum_fin   = acc_sum + (add_en ? SUM_W'(add_e.val) : SUM_W'(0));
    max_fin   = (add_en && add_e.val > acc_max) ? add_e.val : acc_max;
    last_fin  = add_en ? add_e.pos : acc_last;
    sum_sat   = (32'(sum_fin) > 32'(SUM_SAT)) ? SUM_SAT : 22'(sum_fin);
  end

  // Per-slot decision while the read data streams in; append write at finish
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = proc_idx[IDX_W-1:0];
    wr_data   = mem_q;
    use_en    = 1'b0;
    use_e     = mem_q;
    found_set = 1'b0;
    settle    = 1'b0;
    up_set    = 1'b0;
    down_set  = 1'b0;
    carry_ld  = 1'b0;
    if (state == S_FIN) begin
      wr_en   = add_en;
      wr_addr = count[IDX_W-1:0];
      wr_data = add_e;
    end else if (state == S_SCAN && q_valid) begin
      if (shift_down) begin
        wr_en   = 1'b1;
        wr_addr = prev_idx[IDX_W-1:0];
        use_en  = 1'b1;
      end else if (shift_up) begin
        wr_en    = 1'b1;
        wr_data  = carry;
        use_en   = 1'b1;
        use_e    = carry;
        carry_ld = 1'b1;
      end else if (settled) begin
        use_en = 1'b1;
      end else if (mem_q.pos == p) begin
        settle    = 1'b1;
        found_set = 1'b1;
        if (set_nz) begin
          wr_en   = 1'b1;
          wr_data = new_e;
          use_en  = 1'b1;
          use_e   = new_e;
        end else if (is_get == FUNC_SET) begin
          down_set = 1'b1;
        end else begin
          use_en = 1'b1;
        end
      end else if (mem_q.pos > p) begin
        settle = 1'b1;
        if (set_nz && room) begin
          wr_en    = 1'b1;
          wr_data  = new_e;
          use_en   = 1'b1;
          use_e    = new_e;
          up_set   = 1'b1;
          carry_ld = 1'b1;
        end else begin
          use_en = 1'b1;
        end
      end else begin
        use_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      sum      <= '0;
      max      <= '0;
      last_pos <= '0;
      q_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            is_get     <= item.func;
            p          <= item.position;
            v          <= item.entry_value;
            rd_idx     <= '0;
            q_valid    <= 1'b0;
            settled    <= 1'b0;
            shift_up   <= 1'b0;
            shift_down <= 1'b0;
            acc_sum    <= '0;
            acc_max    <= '0;
            acc_last   <= '0;
            had        <= 1'b0;
            rd_val     <= '0;
            if (skip) begin
              res.read_value    <= '0;
              res.had           <= 1'b0;
              res.stat.count    <= 7'(32'(count));
              res.stat.sum      <= sum;
              res.stat.max      <= max;
              res.stat.last_pos <= last_pos;
              state             <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          q_valid  <= rd_en;
          proc_idx <= rd_idx;
          if (rd_en) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (use_en) begin
            acc_sum  <= acc_sum + SUM_W'(use_e.val);
            acc_last <= use_e.pos;
            if (use_e.val > acc_max) begin
              acc_max <= use_e.val;
            end
          end
          if (carry_ld) begin
            carry <= mem_q;
          end
          if (settle) begin
            settled <= 1'b1;
          end
          if (up_set) begin
            shift_up <= 1'b1;
          end
          if (down_set) begin
            shift_down <= 1'b1;
          end
          if (found_set) begin
            had    <= 1'b1;
            rd_val <= (is_get == FUNC_GET) ? mem_q.val : 16'd0;
          end
          if (!rd_en && !q_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          count             <= count_fin;
          sum               <= sum_sat;
          max               <= max_fin;
          last_pos          <= last_fin;
          res.read_value    <= rd_val;
          res.had           <= had;
          res.stat.count    <= 7'(32'(count_fin));
          res.stat.sum      <= sum_sat;
          res.stat.max      <= max_fin;
          res.stat.last_pos <= last_fin;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done_valid = (state == S_DONE);
  assign done_res   = res;

endmodule

// ===== design/sivs_checker.sv =====
// Port-level checks for the sparse index vector store, with bind to the top.
// Depends on sivs_pkg and sparse_index_vector_store.
`timescale 1ns / 1ps

module sivs_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input sivs_pkg::out_item_t out_item
);
  import sivs_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // A range error touches nothing and reads nothing
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.range_error |->
      out_item.read_value == 16'd0 && !out_item.had_nonzero)
    else $error("range error beat carries a read");

  // A nonzero read comes only from a present entry
  a_read_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.read_value != 16'd0 |-> out_item.had_nonzero)
    else $error("nonzero read without a present entry");

  // An empty list has a zero summary
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.nonzero_count == 7'd0 |->
      out_item.total_order == 22'd0 && out_item.largest_value == 16'd0 &&
      !out_item.last_nonzero)
    else $error("empty list with nonzero summary");

  // The maximum never exceeds the sum
  a_max_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 22'(out_item.largest_value) <= out_item.total_order)
    else $error("largest value above total");

endmodule

bind sparse_index_vector_store sivs_checker u_sivs_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

// ===== sim/sparse_index_vector_store_tb.sv =====
// Testbench for sparse_index_vector_store: drives set/get beats, predicts every result
// from a dense copy of the vector and checks each result field. Depends on sivs_pkg.
`timescale 1ns / 1ps

module sparse_index_vector_store_tb;
  import sivs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  // Dense shadow of the sparse vector: a zero value means no list entry.
  logic [15:0] vec_value [64];
  logic [6:0]  length_reg;
  out_item_t   expected_reports [$];
  int          mismatch_count = 0;
  bit          steady = 1'b0;

  sparse_index_vector_store dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all while steady is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one beat to the shadow vector and return the result it must produce.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t   r;
    int unsigned eff;
    int unsigned total;
    int          top_pos;
    r = '0;
    eff = (length_reg > 7'd64) ? 64 : length_reg;
    if (it.position >= eff) begin
      r.range_error = 1'b1;
    end else begin
      r.had_nonzero = (vec_value[it.position] != 16'd0);
      if (it.func == FUNC_GET) begin
        r.read_value = vec_value[it.position];
      end else begin
        // insert, update and erase all collapse to one write in the dense view
        vec_value[it.position] = it.entry_value;
      end
    end
    total = 0;
    top_pos = -1;
    for (int p = 0; p < 64; p++) begin
      if (vec_value[p] != 16'd0) begin
        r.nonzero_count++;
        total += vec_value[p];
        if (vec_value[p] > r.largest_value) r.largest_value = vec_value[p];
        top_pos = p;
      end
    end
    r.total_order = (total > SUM_SAT) ? SUM_SAT : total[21:0];
    // entries kept beyond a lowered length hide the final component
    r.last_nonzero = (eff > 0) && (top_pos == int'(eff) - 1);
    return r;
  endfunction

  // Send one beat; hold valid across back-to-back beats when the gap is zero.
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (!in_ready);
    expected_reports = {expected_reports, apply_item(it)};
  endtask

  task automatic send_op(logic func, logic [5:0] pos, logic [15:0] val);
    in_item_t it;
    it.func        = func;
    it.position    = pos;
    it.entry_value = val;
    send_item(it);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_length(logic [6:0] len);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = len;
    do @(posedge clk); while (!cfg_ready);
    length_reg = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] random_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'hFFFF;
    if (r < 14) return 16'd1;
    return 16'($urandom_range(1, 65535));
  endfunction

  // Mostly legal positions; sets outweigh erases so the list grows deep.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned eff;
    int          sel;
    eff = (length_reg > 7'd64) ? 64 : length_reg;
    if (eff > 0 && $urandom_range(0, 99) < 92) it.position = 6'($urandom_range(0, eff - 1));
    else it.position = 6'($urandom_range(0, 63));
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      it.func = FUNC_SET;
      it.entry_value = random_value();
    end else if (sel < 62) begin
      it.func = FUNC_SET;
      it.entry_value = 16'd0;
    end else begin
      it.func = FUNC_GET;
      it.entry_value = 16'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  task automatic run_phase(logic [6:0] len, int n_items);
    write_length(len);
    repeat (n_items) send_item(random_item());
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Result beats are taken at the rising edge and checked against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("read_value",    want.read_value,    out_item.read_value);
        check_field("had_nonzero",   want.had_nonzero,   out_item.had_nonzero);
        check_field("range_error",   want.range_error,   out_item.range_error);
        check_field("nonzero_count", want.nonzero_count, out_item.nonzero_count);
        check_field("total_order",   want.total_order,   out_item.total_order);
        check_field("largest_value", want.largest_value, out_item.largest_value);
        check_field("last_nonzero",  want.last_nonzero,  out_item.last_nonzero);
      end
    end
  end

  // Receiver: after each ready cycle pick a fresh stall length.
  initial begin : ready_driver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic test_empty_reads();
    send_op(FUNC_GET, 6'd0, 16'h0000);
    send_op(FUNC_GET, 6'd63, 16'hFFFF);
  endtask

  task automatic test_set_get_erase();
    send_op(FUNC_SET, 6'd0, 16'hFFFF);   // insert at the low end
    send_op(FUNC_SET, 6'd63, 16'h0001);  // insert at the high end, last component set
    send_op(FUNC_GET, 6'd63, 16'hFFFF);  // value field ignored on a get
    send_op(FUNC_SET, 6'd0, 16'h8000);   // update in place, maximum drops
    send_op(FUNC_SET, 6'd21, 16'h0000);  // zero to an absent position
    send_op(FUNC_SET, 6'd42, 16'h5555);  // insert in the middle
    send_op(FUNC_GET, 6'd42, 16'h0000);
    send_op(FUNC_SET, 6'd63, 16'h0000);  // erase the tail entry
    send_op(FUNC_GET, 6'd63, 16'h0000);
    send_op(FUNC_SET, 6'd63, 16'hAAAA);
    send_op(FUNC_GET, 6'd0, 16'h0000);
  endtask

  task automatic test_length_register();
    write_length(7'd1);                  // shortest nonzero length, higher entries kept
    send_op(FUNC_SET, 6'd0, 16'h1234);
    send_op(FUNC_SET, 6'd1, 16'h0005);   // out of range
    write_length(7'd0);                  // every position out of range
    send_op(FUNC_GET, 6'd0, 16'h0000);
    send_op(FUNC_SET, 6'd0, 16'h0001);
    write_length(7'd127);                // saturates to 64
    send_op(FUNC_GET, 6'd63, 16'h0000);
    send_op(FUNC_SET, 6'd63, 16'hAAAA);
    write_length(7'd65);
    send_op(FUNC_GET, 6'd63, 16'h0000);
    write_length(7'd40);                 // lowered below live entries
    send_op(FUNC_SET, 6'd39, 16'h5555);
    send_op(FUNC_GET, 6'd63, 16'h0000);
    write_length(7'd64);
  endtask

  // Fill every slot at the largest value for the deepest list and top sum,
  // then read and erase in the middle, refill it and erase the head entry.
  task automatic test_full_list();
    write_length(7'd64);
    for (int p = 0; p < 64; p++) send_op(FUNC_SET, 6'(p), 16'hFFFF);
    send_op(FUNC_GET, 6'd31, 16'h0000);
    send_op(FUNC_SET, 6'd31, 16'h0000);
    send_op(FUNC_SET, 6'd31, 16'h0002);
    send_op(FUNC_SET, 6'd0, 16'h0000);
  endtask

  task automatic test_random_traffic();
    run_phase(7'd2, 40);                 // deep list, tiny window
    run_phase(7'd127, 60);
    run_phase(7'($urandom_range(3, 63)), 60);
    steady = 1'b1;                       // back-to-back on both sides
    run_phase(7'd64, 60);
    steady = 1'b0;
    run_phase(7'd0, 8);
    run_phase(7'($urandom_range(65, 126)), 60);
    run_phase(7'd1, 30);
    run_phase(7'($urandom_range(1, 63)), 60);
  endtask

  // Sender holds off until the store has answered everything in flight.
  task automatic test_drain_pauses();
    write_length(7'd64);
    repeat (8) begin
      repeat (10) send_item(random_item());
      wait_drained();
    end
  endtask

  initial begin
    for (int p = 0; p < 64; p++) vec_value[p] = 16'd0;
    length_reg = LEN_RESET;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_empty_reads();
    test_set_get_erase();
    test_length_register();
    test_full_list();
    test_random_traffic();
    test_drain_pauses();

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS sparse_index_vector_store");
    end else begin
      $display("FAIL sparse_index_vector_store");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL sparse_index_vector_store");
    $finish;
  end

endmodule
